// ===== src/esr_pkg.sv =====
// Shared types, codes and helpers of the serial EEPROM command responder.
package esr_pkg;

    localparam int unsigned STORE_BYTES_DEF = 2048;
    localparam int unsigned LINE_BYTES      = 8;
    localparam int unsigned PADDR_W         = 3;

    // Command codes
    localparam logic [7:0] CMD_STATUS = 8'h00;
    localparam logic [7:0] CMD_READ   = 8'h04;
    localparam logic [7:0] CMD_WRITE  = 8'h05;

    // Save modes
    localparam logic [1:0] MODE_AUTO  = 2'd0;
    localparam logic [1:0] MODE_4K    = 2'd1;
    localparam logic [1:0] MODE_16K   = 2'd2;
    localparam logic [1:0] MODE_OTHER = 2'd3;

    // Register indexes (paddr[2])
    localparam logic REG_SAVE_MODE   = 1'b0;
    localparam logic REG_FORCE_LARGE = 1'b1;

    // Status answer bytes
    localparam logic [7:0] TYPE_4K     = 8'h80;
    localparam logic [7:0] TYPE_16K    = 8'hC0;
    localparam logic [7:0] FLAG_NO_DEV = 8'h80;
    localparam logic [7:0] FLAG_LEN    = 8'h40;
    localparam logic [7:0] LEN_STATUS  = 8'd3;

    typedef struct packed {
        logic [7:0]  func;
        logic [7:0]  rx_len;
        logic [7:0]  line_sel;
        logic [63:0] data;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  rx_len;
        logic [7:0]  line_sel;
        logic [63:0] data;
    } rsp_t;

    // Line number modulo the line count; count is at least 64, so four
    // compare-and-subtract steps cover any 8-bit value.
    function automatic logic [7:0] line_wrap(input logic [7:0] sel, input logic [8:0] count);
        logic [8:0] r;
        r = {1'b0, sel};
        for (int i = 0; i < 4; i++)
        begin
            if (r >= count)
            begin
                r = r - count;
            end
        end
        return r[7:0];
    endfunction

endpackage

// ===== src/esr_cmd_if.sv =====
// Command word channel: valid/ready plus one bus frame.
interface esr_cmd_if;
    logic        valid;
    logic        ready;
    logic [7:0]  func;
    logic [7:0]  rx_len;
    logic [7:0]  line_sel;
    logic [63:0] data_in;

    modport source (output valid, func, rx_len, line_sel, data_in, input ready);
    modport sink   (input valid, func, rx_len, line_sel, data_in, output ready);
endinterface

// ===== src/esr_rsp_if.sv =====
// Response word channel: valid/ready plus the frame as the device leaves it.
interface esr_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rx_len_out;
    logic [7:0]  line_out;
    logic [63:0] data_out;

    modport source (output valid, rx_len_out, line_out, data_out, input ready);
    modport sink   (input valid, rx_len_out, line_out, data_out, output ready);
endinterface

// ===== src/esr_ram.sv =====
// Generic single-port-write, registered-read RAM.
module esr_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== src/esr_cfg.sv =====
// APB register file: save mode, force flag and auto-mode resolution.
module esr_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [esr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    input  logic                        resolve,
    output logic [1:0]                  eff_mode
);
    import esr_pkg::*;

    logic [1:0] mode_reg, mode_next;
    logic       force_reg, force_next;
    logic       wr;

    assign wr       = psel && penable && pwrite;
    assign eff_mode = (mode_reg == MODE_AUTO) ? (force_reg ? MODE_16K : MODE_4K) : mode_reg;

    always_comb
    begin
        mode_next  = mode_reg;
        force_next = force_reg;
        // auto mode sticks to what it resolved to on the first command
        if (resolve && mode_reg == MODE_AUTO)
        begin
            mode_next = eff_mode;
        end
        if (wr)
        begin
            case (paddr[2])
                REG_SAVE_MODE:   mode_next  = pwdata[1:0];
                REG_FORCE_LARGE: force_next = pwdata[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_AUTO;
            force_reg <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            force_reg <= force_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[1:0] == 2'b00)
        begin
            case (paddr[2])
                REG_SAVE_MODE:   prdata = {30'd0, mode_reg};
                REG_FORCE_LARGE: prdata = {31'd0, force_reg};
                default:         prdata = '0;
            endcase
        end
    end
endmodule

// ===== src/esr_resp.sv =====
// Response formation: status answer, line read data, pass-through.
module esr_resp (
    input  esr_pkg::cmd_t cmd,
    input  logic [63:0]   rd_data,
    input  logic          rd_hit,
    input  logic [1:0]    mode,
    output esr_pkg::rsp_t rsp
);
    import esr_pkg::*;

    logic       is_eeprom;
    logic [7:0] type_code;
    logic [1:0] k;

    assign is_eeprom = mode inside {MODE_4K, MODE_16K};
    assign type_code = (mode == MODE_4K) ? TYPE_4K : TYPE_16K;
    assign k         = cmd.rx_len[1:0];

    always_comb
    begin
        rsp.rx_len   = cmd.rx_len;
        rsp.line_sel = cmd.line_sel;
        rsp.data     = cmd.data;
        case (cmd.func)
            CMD_STATUS:
            begin
                if (!is_eeprom)
                begin
                    rsp.rx_len = cmd.rx_len | FLAG_NO_DEV;
                end
                else if (cmd.rx_len == LEN_STATUS)
                begin
                    rsp.line_sel   = 8'h00;
                    rsp.data[15:0] = {8'h00, type_code};
                end
                else
                begin
                    // short answer: only the first k bytes are written
                    rsp.rx_len = cmd.rx_len | FLAG_LEN;
                    if (k > 2'd0)
                    begin
                        rsp.line_sel = 8'h00;
                    end
                    if (k > 2'd1)
                    begin
                        rsp.data[7:0] = type_code;
                    end
                    if (k > 2'd2)
                    begin
                        rsp.data[15:8] = 8'h00;
                    end
                end
            end
            CMD_READ:
            begin
                rsp.data = rd_hit ? rd_data : 64'd0;
            end
            default:
            begin
            end
        endcase
    end
endmodule

// ===== src/serial_eeprom_command_responder.sv =====
// Top level of the serial EEPROM command responder.
//
//  channel | dir | handshake        | word
//  --------+-----+------------------+-----------------------------------------
//  cmd     | in  | valid/ready      | func, rx_len, line_sel, data_in
//  rsp     | out | valid/ready      | rx_len_out, line_out, data_out
//  apb     | in  | psel/penable     | save_mode @0x0, force_large @0x4
//
//  One word can be accepted every cycle while rsp does not stall; its response goes
//  through the input register, the line RAM read register and the output register.
//  Each word reads one line of a registered-read RAM; a write word also writes that line.
//  Reset makes every line read as zero at once: one valid flop per line, no clearing pass.
//  Stalls on rsp back up stage by stage; cmd.ready drops only when all three
//  stages hold a word.
module serial_eeprom_command_responder #(
    parameter int unsigned STORE_BYTES = esr_pkg::STORE_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    esr_cmd_if.sink                     cmd,
    esr_rsp_if.source                   rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [esr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import esr_pkg::*;

    localparam int unsigned LINE_COUNT = STORE_BYTES / LINE_BYTES;
    localparam int unsigned ADDR_W     = $clog2(LINE_COUNT);

    // pipeline control
    logic o_adv, s2_adv, s1_adv;

    // stage 1: registered command and wrapped line index
    logic              s1_valid_reg;
    cmd_t              s1_cmd_reg;
    logic [ADDR_W-1:0] s1_idx_reg;
    logic [7:0]        in_wrap;

    // stage 2: command alongside RAM read data
    logic        s2_valid_reg;
    cmd_t        s2_cmd_reg;
    logic        s2_hit_reg;
    logic [63:0] ram_rdata;

    // output register
    logic        o_valid_reg;
    rsp_t        o_rsp_reg;
    rsp_t        rsp_next;

    // store
    logic [LINE_COUNT-1:0] line_valid_reg;
    logic                  ram_we;

    logic [1:0] eff_mode;
    logic       resolve;

    assign pready = 1'b1;

    assign o_adv  = !o_valid_reg || rsp.ready;
    assign s2_adv = !s2_valid_reg || o_adv;
    assign s1_adv = !s1_valid_reg || s2_adv;

    assign cmd.ready = s1_adv;

    assign in_wrap = line_wrap(cmd.line_sel, 9'(LINE_COUNT));

    // a write lands as its word leaves stage 1, before any later read issues
    assign ram_we  = s2_adv && s1_valid_reg && (s1_cmd_reg.func == CMD_WRITE);
    assign resolve = o_adv && s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_cmd_reg <= '{func: cmd.func, rx_len: cmd.rx_len,
                            line_sel: cmd.line_sel, data: cmd.data_in};
            s1_idx_reg <= in_wrap[ADDR_W-1:0];
        end
    end

    esr_ram #(
        .WIDTH (64),
        .DEPTH (LINE_COUNT)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_idx_reg),
        .wdata (s1_cmd_reg.data),
        .re    (s2_adv),
        .raddr (s1_idx_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_valid_reg <= '0;
        end
        else if (ram_we)
        begin
            line_valid_reg[s1_idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            s2_cmd_reg <= s1_cmd_reg;
            s2_hit_reg <= line_valid_reg[s1_idx_reg];
        end
    end

    esr_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .resolve  (resolve),
        .eff_mode (eff_mode)
    );

    esr_resp u_resp (
        .cmd     (s2_cmd_reg),
        .rd_data (ram_rdata),
        .rd_hit  (s2_hit_reg),
        .mode    (eff_mode),
        .rsp     (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (o_adv)
        begin
            o_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_adv)
        begin
            o_rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid      = o_valid_reg;
    assign rsp.rx_len_out = o_rsp_reg.rx_len;
    assign rsp.line_out   = o_rsp_reg.line_sel;
    assign rsp.data_out   = o_rsp_reg.data;

    // ---------------------------------------------------------------- checks

    // input back-pressure only when every stage is full and rsp is stalled
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> (rsp.valid && !rsp.ready))
        else $error("cmd stalled with room in the pipeline");

    // a written line is marked valid from then on
    a_write_marks: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> line_valid_reg[$past(s1_idx_reg)])
        else $error("line write did not set its valid bit");

    // a read of a never-written line answers zero
    a_cold_read: assert property (@(posedge clk) disable iff (!rst_n)
        (o_adv && s2_valid_reg && (s2_cmd_reg.func == CMD_READ) && !s2_hit_reg)
        |=> (rsp.data_out == 64'd0))
        else $error("read of unwritten line returned nonzero data");

endmodule
